// File: hw/rtl/fbpm_pkg.sv
// ----------------------------------------------------------------------------
// fbpm_pkg
// Shared types, codes and sizes of the frame buffer pool manager.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpm_pkg;

  // pool geometry
  localparam int MAX_SLOTS = 32;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = 6;
  localparam int BYTES_W   = 27;
  localparam int SADDR_W   = 26;
  localparam int NEED_W    = BYTES_W + CNT_W;
  localparam logic [NEED_W-1:0] POOL_BYTES = NEED_W'(67108864);

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [BYTES_W-1:0] SLOT_BYTES_RST   = BYTES_W'(4096);
  localparam logic [CNT_W-1:0]   BUFFER_COUNT_RST = CNT_W'(4);

  // register indexes (byte address bit 2)
  localparam logic REG_SLOT_BYTES   = 1'b0;
  localparam logic REG_BUFFER_COUNT = 1'b1;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_LOCK   = 3'd3,
    CMD_UNLOCK = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_FULL          = 3'd1,
    ST_NO_MEMORY     = 3'd2,
    ST_NOTHING_READY = 3'd3,
    ST_NOT_HELD      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic [BYTES_W-1:0] slot_bytes;
    logic [CNT_W-1:0]   buffer_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  slot_index;
    logic [SADDR_W-1:0] slot_address;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   ready_count;
    logic [CNT_W-1:0]   held_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/fbpm_ram.sv
// ----------------------------------------------------------------------------
// fbpm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbpm_cfg.sv
// ----------------------------------------------------------------------------
// fbpm_cfg
// APB register file holding slot size and buffer count.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_cfg import fbpm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [BYTES_W-1:0] slot_bytes_r;
  logic [CNT_W-1:0]   buffer_count_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r   <= SLOT_BYTES_RST;
      buffer_count_r <= BUFFER_COUNT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SLOT_BYTES:   slot_bytes_r   <= pwdata[BYTES_W-1:0];
        REG_BUFFER_COUNT: buffer_count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_SLOT_BYTES:   prdata = APB_DW'(slot_bytes_r);
      REG_BUFFER_COUNT: prdata = APB_DW'(buffer_count_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.slot_bytes   = slot_bytes_r;
  assign cfg.buffer_count = buffer_count_r;

endmodule

`default_nettype wire

// File: hw/rtl/fbpm_engine.sv
// ----------------------------------------------------------------------------
// fbpm_engine
// Command sequencer: reads queue heads, updates pointers and held mask,
// writes queue entries back and registers one result beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_engine import fbpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic [BYTES_W-1:0] in_frame_bytes,
  input  wire logic [SLOT_W-1:0]  in_release_index,
  input  wire logic               in_release_given,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output result_t                 result,
  output ram_req_t                free_req,
  input  wire logic [SLOT_W-1:0]  free_rdata,
  output ram_req_t                ready_req,
  input  wire logic [SLOT_W-1:0]  ready_rdata
);

  state_t state_r, state_nxt;

  // accepted command
  logic [2:0]         cmd_r;
  logic [BYTES_W-1:0] frame_r;
  logic [SLOT_W-1:0]  rel_idx_r;
  logic               rel_given_r;

  // queue and pool state
  logic [SLOT_W-1:0]    fhead_r, fhead_nxt, rhead_r, rhead_nxt;
  logic [CNT_W-1:0]     fcount_r, fcount_nxt, rcount_r, rcount_nxt;
  logic [CNT_W-1:0]     hcount_r, hcount_nxt;
  logic [MAX_SLOTS-1:0] held_r, held_nxt;
  logic [BYTES_W-1:0]   active_r, active_nxt;
  logic                 init_ok_r;
  logic [CNT_W-1:0]     sweep_cnt_r, sweep_n_r, sweep_n_nxt;
  logic [CNT_W-1:0]     sweep_inc;

  logic                 out_valid_r;
  result_t              result_r;

  logic                 accept, exec_fire, go_sweep;
  logic [NEED_W-1:0]    need;
  logic [2:0]           status;
  logic                 handed;
  logic [SLOT_W-1:0]    slot;
  logic [31:0]          addr_prod;
  logic                 fpush, rpush;
  logic [SLOT_W-1:0]    fpush_addr, rpush_addr;

  assign accept    = in_valid & ~in_stall;
  assign exec_fire = (state_r == S_EXEC) & (~out_valid_r | ~out_stall);
  assign need      = NEED_W'(cfg.slot_bytes) * NEED_W'(cfg.buffer_count);
  assign sweep_inc = CNT_W'(sweep_cnt_r + CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_EXEC;
      S_EXEC:  if (exec_fire) state_nxt = go_sweep ? S_SWEEP : S_IDLE;
      S_SWEEP: if (sweep_inc == sweep_n_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: stall and memory ports
  always_comb begin
    in_stall        = (state_r != S_IDLE);
    free_req.re     = (state_r == S_READ);
    free_req.raddr  = fhead_r;
    ready_req.re    = (state_r == S_READ);
    ready_req.raddr = rhead_r;
    ready_req.we    = exec_fire & rpush;
    ready_req.waddr = rpush_addr;
    ready_req.wdata = slot;
    if (state_r == S_SWEEP) begin
      free_req.we    = 1'b1;
      free_req.waddr = sweep_cnt_r[SLOT_W-1:0];
      free_req.wdata = sweep_cnt_r[SLOT_W-1:0];
    end else begin
      free_req.we    = exec_fire & fpush;
      free_req.waddr = fpush_addr;
      free_req.wdata = rel_idx_r;
    end
  end

  // command datapath, committed on exec_fire
  always_comb begin
    fhead_nxt   = fhead_r;
    rhead_nxt   = rhead_r;
    fcount_nxt  = fcount_r;
    rcount_nxt  = rcount_r;
    hcount_nxt  = hcount_r;
    held_nxt    = held_r;
    active_nxt  = active_r;
    sweep_n_nxt = sweep_n_r;
    go_sweep    = 1'b0;
    status      = ST_OK;
    handed      = 1'b0;
    slot        = '0;
    fpush       = 1'b0;
    rpush       = 1'b0;
    fpush_addr  = SLOT_W'(fhead_r + fcount_r[SLOT_W-1:0]);
    rpush_addr  = SLOT_W'(rhead_r + rcount_r[SLOT_W-1:0]);
    case (cmd_r)
      CMD_INIT: begin
        fhead_nxt  = '0;
        rhead_nxt  = '0;
        fcount_nxt = '0;
        rcount_nxt = '0;
        hcount_nxt = '0;
        held_nxt   = '0;
        if (!init_ok_r) begin
          status = ST_NO_MEMORY;
        end else begin
          active_nxt  = cfg.slot_bytes;
          fcount_nxt  = cfg.buffer_count;
          sweep_n_nxt = cfg.buffer_count;
          go_sweep    = (cfg.buffer_count != '0);
        end
      end
      CMD_CLEAR: begin
        fhead_nxt  = '0;
        rhead_nxt  = '0;
        fcount_nxt = '0;
        rcount_nxt = '0;
        hcount_nxt = '0;
        held_nxt   = '0;
      end
      CMD_FILL: begin
        if (fcount_r == '0) begin
          status = ST_FULL;
        end else if (frame_r > active_r) begin
          status = ST_NO_MEMORY;
        end else begin
          slot       = free_rdata;
          handed     = 1'b1;
          fhead_nxt  = SLOT_W'(fhead_r + SLOT_W'(1));
          fcount_nxt = CNT_W'(fcount_r - CNT_W'(1));
          if (rcount_r != CNT_W'(MAX_SLOTS)) begin
            rpush      = 1'b1;
            rcount_nxt = CNT_W'(rcount_r + CNT_W'(1));
          end
        end
      end
      CMD_LOCK: begin
        if (rcount_r == '0) begin
          status = ST_NOTHING_READY;
        end else begin
          slot       = ready_rdata;
          handed     = 1'b1;
          rhead_nxt  = SLOT_W'(rhead_r + SLOT_W'(1));
          rcount_nxt = CNT_W'(rcount_r - CNT_W'(1));
          if (!held_r[slot]) begin
            hcount_nxt = CNT_W'(hcount_r + CNT_W'(1));
          end
          held_nxt[slot] = 1'b1;
        end
      end
      CMD_UNLOCK: begin
        if (rel_given_r) begin
          if (held_r[rel_idx_r]) begin
            held_nxt[rel_idx_r] = 1'b0;
            hcount_nxt          = CNT_W'(hcount_r - CNT_W'(1));
            if (fcount_r != CNT_W'(MAX_SLOTS)) begin
              fpush      = 1'b1;
              fcount_nxt = CNT_W'(fcount_r + CNT_W'(1));
            end
          end else begin
            status = ST_NOT_HELD;
          end
        end
      end
      default: ;
    endcase
  end

  assign addr_prod = 32'(slot) * 32'(active_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fhead_r     <= '0;
      rhead_r     <= '0;
      fcount_r    <= '0;
      rcount_r    <= '0;
      hcount_r    <= '0;
      held_r      <= '0;
      active_r    <= SLOT_BYTES_RST;
      sweep_cnt_r <= '0;
      sweep_n_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        fhead_r     <= fhead_nxt;
        rhead_r     <= rhead_nxt;
        fcount_r    <= fcount_nxt;
        rcount_r    <= rcount_nxt;
        hcount_r    <= hcount_nxt;
        held_r      <= held_nxt;
        active_r    <= active_nxt;
        sweep_n_r   <= sweep_n_nxt;
        sweep_cnt_r <= '0;
      end else if (state_r == S_SWEEP) begin
        sweep_cnt_r <= sweep_inc;
      end
      // result beat holds until taken
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command capture and init check
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_command;
      frame_r     <= in_frame_bytes;
      rel_idx_r   <= in_release_index;
      rel_given_r <= in_release_given;
    end
    if (state_r == S_READ) begin
      init_ok_r <= (cfg.buffer_count <= CNT_W'(MAX_SLOTS)) && (need <= POOL_BYTES);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result_r.status       <= status;
      result_r.slot_index   <= handed ? slot : '0;
      result_r.slot_address <= handed ? addr_prod[SADDR_W-1:0] : '0;
      result_r.free_count   <= fcount_nxt;
      result_r.ready_count  <= rcount_nxt;
      result_r.held_count   <= hcount_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// File: hw/rtl/frame_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager
// Free / ready / held queue manager for a pool of equal frame slots.
// ----------------------------------------------------------------------------
// Commands enter on the in_ channel (init, clear, fill, lock, unlock) and each
// gives exactly one result beat on the out_ channel: status, slot index and
// byte address, and the free, ready and held counts after the command.
// The user must set slot size and buffer count through the APB port while
// idle; the block does not enforce this. A command is accepted only in the
// idle state; the cycle after acceptance the queue memories are read at
// their heads, then the update is written back and the result registered
// once the output channel can take it, and only then can a new command be
// taken. A successful init with a buffer count of n then writes n slot
// numbers into the free queue memory before the next command is accepted.
// Only one command is in flight, so a memory read never overlaps a write to
// the same entry. A stalled result beat holds; the command behind it waits
// in the write-back step until the beat is taken.
// Reset empties all queues, clears held slots, sets slot size to 4096 and
// buffer count to 4; the queue memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_pool_manager import fbpm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_command,
  input  wire logic [BYTES_W-1:0]  in_frame_bytes,
  input  wire logic [SLOT_W-1:0]   in_release_index,
  input  wire logic                in_release_given,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic [SLOT_W-1:0]        out_slot_index,
  output logic [SADDR_W-1:0]       out_slot_address,
  output logic [CNT_W-1:0]         out_free_count,
  output logic [CNT_W-1:0]         out_ready_count,
  output logic [CNT_W-1:0]         out_held_count,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  cfg_t              cfg;
  ram_req_t          free_req, ready_req;
  logic [SLOT_W-1:0] free_rdata, ready_rdata;
  result_t           result;

  // configuration registers
  fbpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // free queue entries
  fbpm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (free_req.we),
    .waddr (free_req.waddr),
    .wdata (free_req.wdata),
    .re    (free_req.re),
    .raddr (free_req.raddr),
    .rdata (free_rdata)
  );

  // ready queue entries
  fbpm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_ready_ram (
    .clk   (clk),
    .we    (ready_req.we),
    .waddr (ready_req.waddr),
    .wdata (ready_req.wdata),
    .re    (ready_req.re),
    .raddr (ready_req.raddr),
    .rdata (ready_rdata)
  );

  // command sequencer
  fbpm_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_frame_bytes   (in_frame_bytes),
    .in_release_index (in_release_index),
    .in_release_given (in_release_given),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result           (result),
    .free_req         (free_req),
    .free_rdata       (free_rdata),
    .ready_req        (ready_req),
    .ready_rdata      (ready_rdata)
  );

  assign out_status       = result.status;
  assign out_slot_index   = result.slot_index;
  assign out_slot_address = result.slot_address;
  assign out_free_count   = result.free_count;
  assign out_ready_count  = result.ready_count;
  assign out_held_count   = result.held_count;

endmodule

`default_nettype wire

// File: hw/rtl/fbpm_checker.sv
// ----------------------------------------------------------------------------
// fbpm_checker
// Port-level checks of the frame buffer pool manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpm_checker import fbpm_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         out_status,
  input wire logic [SLOT_W-1:0]  out_slot_index,
  input wire logic [SADDR_W-1:0] out_slot_address,
  input wire logic [CNT_W-1:0]   out_free_count,
  input wire logic [CNT_W-1:0]   out_ready_count,
  input wire logic [CNT_W-1:0]   out_held_count
);

  logic [CNT_W+1:0] slot_total;
  assign slot_total = (CNT_W+2)'(out_free_count) + (CNT_W+2)'(out_ready_count)
                    + (CNT_W+2)'(out_held_count);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // one command at a time: the cycle after acceptance the input stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command accepted while one is in flight");

  // a stalled result beat holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_slot_index) && $stable(out_slot_address))
    else $error("stalled result beat changed");

  // a failed command names no slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_slot_index == '0 && out_slot_address == '0)
    else $error("failed command returned a slot");

  // the free, ready and held counts never sum to more than the pool's slots
  a_slot_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slot_total <= (CNT_W+2)'(MAX_SLOTS))
    else $error("more slots in use than the pool holds");

endmodule

bind frame_buffer_pool_manager fbpm_checker u_fbpm_checker (.*);

`default_nettype wire

// File: test/frame_buffer_pool_manager_tb.sv
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_tb
// Self-checking bench for the frame slot pool (free, ready and held queues).
// A tracker class mirrors the queues and the latched slot size, predicts the
// result of every accepted command and checks each result beat in order.
// A directed opening is followed by random command streams under many pool
// settings, with random gaps and stalls, one long receiver hold-off and one
// sender pause until the pool is drained.
// ----------------------------------------------------------------------------

module frame_buffer_pool_manager_tb;
  import fbpm_pkg::*;

  // unused command codes, ignored by the block
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 50;
  localparam int HOLD_CYCLES  = 300;
  localparam int SHOW_LIMIT   = 10;
  localparam int N_FIXED      = 10;
  localparam int N_RANDOM     = 8;
  localparam int RANDOM_ITEMS = 150;

  typedef struct packed {
    logic [2:0]         command;
    logic [BYTES_W-1:0] frame_bytes;
    logic [SLOT_W-1:0]  release_index;
    logic               release_given;
  } pool_cmd_s;

  // --------------------------------------------------------------------------
  // tracker: mirrors the pool and checks result beats in order
  // --------------------------------------------------------------------------
  class slot_pool_tracker;
    logic [BYTES_W-1:0] slot_bytes_reg;
    logic [CNT_W-1:0]   buffer_count_reg;
    logic [BYTES_W-1:0] live_slot_bytes;
    logic [SLOT_W-1:0]  free_fifo[$];
    logic [SLOT_W-1:0]  ready_fifo[$];
    logic [MAX_SLOTS-1:0] held_mask;
    result_t            due_results[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        commands;
    int unsigned        status_seen[5];

    function new();
      slot_bytes_reg   = SLOT_BYTES_RST;
      buffer_count_reg = BUFFER_COUNT_RST;
      live_slot_bytes  = SLOT_BYTES_RST;
      empty_all();
      mismatches = 0;
      checked    = 0;
      commands   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void empty_all();
      free_fifo.delete();
      ready_fifo.delete();
      held_mask = '0;
    endfunction

    function void write_reg(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_SLOT_BYTES) begin
        slot_bytes_reg = value[BYTES_W-1:0];
      end else begin
        buffer_count_reg = value[CNT_W-1:0];
      end
    endfunction

    // work out the result of one accepted command and queue it
    function void note_command(pool_cmd_s c);
      result_t           r;
      logic [SLOT_W-1:0] slot;
      logic              handed;
      longint unsigned   need;
      logic [63:0]       addr;
      r      = '0;
      slot   = '0;
      handed = 1'b0;
      r.status = ST_OK;
      commands++;
      case (c.command)
        CMD_INIT: begin
          need = longint'(slot_bytes_reg) * longint'(buffer_count_reg);
          empty_all();
          if (buffer_count_reg > MAX_SLOTS || need > POOL_BYTES) begin
            r.status = ST_NO_MEMORY;
          end else begin
            live_slot_bytes = slot_bytes_reg;
            for (int i = 0; i < buffer_count_reg; i++)
              free_fifo.insert(free_fifo.size(), SLOT_W'(i));
          end
        end
        CMD_CLEAR: begin
          empty_all();
        end
        CMD_FILL: begin
          if (free_fifo.size() == 0) begin
            r.status = ST_FULL;
          end else if (c.frame_bytes > live_slot_bytes) begin
            r.status = ST_NO_MEMORY;
          end else begin
            slot = free_fifo[0];
            free_fifo.delete(0);
            ready_fifo.insert(ready_fifo.size(), slot);
            handed = 1'b1;
          end
        end
        CMD_LOCK: begin
          if (ready_fifo.size() == 0) begin
            r.status = ST_NOTHING_READY;
          end else begin
            slot = ready_fifo[0];
            ready_fifo.delete(0);
            held_mask[slot] = 1'b1;
            handed = 1'b1;
          end
        end
        CMD_UNLOCK: begin
          if (c.release_given) begin
            if (held_mask[c.release_index]) begin
              held_mask[c.release_index] = 1'b0;
              free_fifo.insert(free_fifo.size(), c.release_index);
            end else begin
              r.status = ST_NOT_HELD;
            end
          end
        end
        default: ;
      endcase
      addr = 64'(slot) * 64'(live_slot_bytes);
      r.slot_index   = handed ? slot : '0;
      r.slot_address = handed ? addr[SADDR_W-1:0] : '0;
      r.free_count   = CNT_W'(free_fifo.size());
      r.ready_count  = CNT_W'(ready_fifo.size());
      r.held_count   = CNT_W'($countones(held_mask));
      status_seen[r.status]++;
      due_results.insert(due_results.size(), r);
    endfunction

    // compare one result beat with the oldest pending one
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("result beat with nothing pending: status %0d index %0d",
                   got.status, got.slot_index);
        return;
      end
      want = due_results[0];
      due_results.delete(0);
      checked++;
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.slot_address !== want.slot_address ||
          got.free_count !== want.free_count || got.ready_count !== want.ready_count ||
          got.held_count !== want.held_count) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display({"mismatch on result %0d (expected/actual): status %0d/%0d",
                    " index %0d/%0d address %h/%h"},
                   checked, want.status, got.status, want.slot_index, got.slot_index,
                   want.slot_address, got.slot_address);
          $display("  free %0d/%0d ready %0d/%0d held %0d/%0d",
                   want.free_count, got.free_count, want.ready_count, got.ready_count,
                   want.held_count, got.held_count);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_command;
  logic [BYTES_W-1:0] in_frame_bytes;
  logic [SLOT_W-1:0]  in_release_index;
  logic               in_release_given;
  logic               out_valid;
  logic               out_stall;
  result_t            out_beat;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  slot_pool_tracker pool;
  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  frame_buffer_pool_manager i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_frame_bytes   (in_frame_bytes),
    .in_release_index (in_release_index),
    .in_release_given (in_release_given),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_beat.status),
    .out_slot_index   (out_beat.slot_index),
    .out_slot_address (out_beat.slot_address),
    .out_free_count   (out_beat.free_count),
    .out_ready_count  (out_beat.ready_count),
    .out_held_count   (out_beat.held_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = rx_idle_on && ($urandom_range(99) < 18);
    end
  end

  // check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pool.check_result(out_beat);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("frame_buffer_pool_manager test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  function automatic pool_cmd_s mk(logic [2:0] command, logic [BYTES_W-1:0] frame_bytes,
                                   logic [SLOT_W-1:0] release_index, logic release_given);
    pool_cmd_s c;
    c.command       = command;
    c.frame_bytes   = frame_bytes;
    c.release_index = release_index;
    c.release_given = release_given;
    return c;
  endfunction

  // offer one command beat, called and returning at a falling edge
  task automatic send_cmd(input pool_cmd_s c);
    while (tx_idle_on && $urandom_range(99) < 18) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_command       = c.command;
    in_frame_bytes   = c.frame_bytes;
    in_release_index = c.release_index;
    in_release_given = c.release_given;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_command(c);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pool.due_results.size() != 0) @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool.write_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // mostly sensible traffic: fills that fit, locks, unlocks of held slots
  function automatic pool_cmd_s random_command();
    pool_cmd_s c;
    int unsigned pick;
    int unsigned held_list[$];
    c.frame_bytes   = BYTES_W'($urandom);
    c.release_index = SLOT_W'($urandom);
    c.release_given = 1'b1;
    pick = $urandom_range(99);
    if (pick < 3) begin
      c.command = CMD_INIT;
    end else if (pick < 5) begin
      c.command = CMD_CLEAR;
    end else if (pick < 35) begin
      c.command = CMD_FILL;
      pick = $urandom_range(99);
      if (pick < 80) begin
        c.frame_bytes = BYTES_W'($urandom_range(0, pool.live_slot_bytes));
      end else if (pick < 90) begin
        c.frame_bytes = pool.live_slot_bytes + 1'b1;
      end
    end else if (pick < 60) begin
      c.command = CMD_LOCK;
    end else if (pick < 94) begin
      c.command = CMD_UNLOCK;
      for (int i = 0; i < MAX_SLOTS; i++)
        if (pool.held_mask[i]) held_list.insert(held_list.size(), i);
      if (held_list.size() != 0 && $urandom_range(99) < 75)
        c.release_index = SLOT_W'(held_list[$urandom_range(held_list.size() - 1)]);
      c.release_given = ($urandom_range(99) < 90);
    end else begin
      c.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      c.release_given = 1'($urandom);
    end
    return c;
  endfunction

  // pool settings: extremes, refusals, zero slots, zero size
  int unsigned fixed_bytes[N_FIXED] = '{67108864, 67108864, 134217727, 1, 2097152,
                                        2097153, 1, 4096, 1000, 0};
  int unsigned fixed_count[N_FIXED] = '{1, 2, 1, 32, 32, 32, 33, 63, 0, 5};
  int unsigned fixed_items[N_FIXED] = '{60, 20, 20, 160, 160, 20, 20, 20, 20, 60};

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned setting_bytes;
    int unsigned setting_count;
    int unsigned item_total;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_INIT;
    in_frame_bytes   = '0;
    in_release_index = '0;
    in_release_given = 1'b0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    hold_request     = 0;
    hold_left        = 0;
    quiet_cycles     = 0;
    pool = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed opening at the reset settings (4096 bytes, 4 slots)
    send_cmd(mk(CMD_LOCK, 0, 0, 1'b0));                   // nothing ready
    send_cmd(mk(CMD_FILL, 0, 0, 1'b0));                   // no free slot
    send_cmd(mk(CMD_UNLOCK, 0, 31, 1'b1));                // slot not held
    send_cmd(mk(CMD_UNLOCK, 0, 5, 1'b0));                 // unlock without a slot
    send_cmd(mk(CMD_SPARE_FIRST, '1, 31, 1'b1));          // unknown commands
    send_cmd(mk(CMD_SPARE_LAST, 0, 0, 1'b0));
    send_cmd(mk(CMD_INIT, 0, 0, 1'b0));
    send_cmd(mk(CMD_FILL, 4096, 0, 1'b0));                // exactly one slot
    send_cmd(mk(CMD_FILL, 4097, 0, 1'b0));                // oversized frame
    send_cmd(mk(CMD_FILL, '1, 0, 1'b0));
    send_cmd(mk(CMD_FILL, 0, 0, 1'b0));
    send_cmd(mk(CMD_FILL, 1, 0, 1'b0));
    send_cmd(mk(CMD_FILL, 100, 0, 1'b0));
    send_cmd(mk(CMD_FILL, 1, 0, 1'b0));                   // pool now full
    send_cmd(mk(CMD_LOCK, 0, 0, 1'b0));
    send_cmd(mk(CMD_LOCK, 0, 0, 1'b0));
    send_cmd(mk(CMD_UNLOCK, 0, 0, 1'b1));
    send_cmd(mk(CMD_UNLOCK, 0, 0, 1'b1));                 // second release refused
    send_cmd(mk(CMD_UNLOCK, 0, 31, 1'b1));
    send_cmd(mk(CMD_LOCK, 0, 0, 1'b0));
    send_cmd(mk(CMD_CLEAR, 0, 0, 1'b0));
    send_cmd(mk(CMD_LOCK, 0, 0, 1'b0));
    send_cmd(mk(CMD_INIT, 0, 0, 1'b0));
    send_cmd(mk(CMD_UNLOCK, 0, 1, 1'b1));
    send_cmd(mk(CMD_SPARE_MID, 0, 0, 1'b1));

    // one stream of random commands per pool setting
    for (int p = 0; p < N_FIXED + N_RANDOM; p++) begin
      if (p < N_FIXED) begin
        setting_bytes = fixed_bytes[p];
        setting_count = fixed_count[p];
        item_total    = fixed_items[p];
      end else begin
        setting_bytes = $urandom_range(1, 1 << 21);
        setting_count = $urandom_range(1, MAX_SLOTS);
        item_total    = RANDOM_ITEMS;
      end
      // registers change only with the pool quiet, init sweep included
      wait_drained();
      repeat (SETTLE) @(negedge clk);
      apb_write(REG_SLOT_BYTES, setting_bytes);
      apb_write(REG_BUFFER_COUNT, setting_count);
      tx_idle_on = (p != 4);
      rx_idle_on = (p != 4);
      send_cmd(mk(CMD_INIT, 0, 0, 1'b0));
      for (int i = 0; i < item_total; i++) begin
        if (p == 3 && i == 10) hold_request = HOLD_CYCLES;
        if (p == 3 && i == item_total / 2) wait_drained();
        send_cmd(random_command());
      end
    end

    wait_drained();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d commands over %0d pool settings, %0d result beats checked",
             pool.commands, N_FIXED + N_RANDOM + 1, pool.checked);
    $display("status mix: ok %0d full %0d no_memory %0d nothing_ready %0d not_held %0d",
             pool.status_seen[ST_OK], pool.status_seen[ST_FULL],
             pool.status_seen[ST_NO_MEMORY], pool.status_seen[ST_NOTHING_READY],
             pool.status_seen[ST_NOT_HELD]);
    if (pool.mismatches == 0 && pool.due_results.size() == 0) begin
      $display("frame_buffer_pool_manager test passed");
    end else begin
      $display("frame_buffer_pool_manager test failed");
    end
    $finish;
  end

endmodule
